[sv/kws_pkg.sv]
// ----------------------------------------------------------------------------
// kws_pkg
// Shared constants, types and the fixed pad table of the word scrambler.
// ----------------------------------------------------------------------------
package kws_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned ROT_W   = 5;

	localparam logic [WORD_W-1:0] WORD_ADD   = 32'h0015_C3E7;
	localparam logic [7:0]         BYTE_SUB   = 8'h37;
	localparam logic [3:0]         SHIFT_SEED = 4'd5;
	localparam logic [ROT_W-1:0]   SHIFT_BASE = 5'd8;

	typedef struct packed {
		logic [WORD_W-1:0] key;
		logic [ROT_W-1:0]  rot;
	} kws_cfg_t;

	function automatic logic [WORD_W-1:0] pad_rom(input logic [INDEX_W-1:0] idx);
		logic [WORD_W-1:0] w;
		case (idx)
			4'd0:    w = 32'h3A68_CDBF;
			4'd1:    w = 32'hD3C3_A711;
			4'd2:    w = 32'h8414_876E;
			4'd3:    w = 32'h657B_EFDB;
			4'd4:    w = 32'hCDD7_C125;
			4'd5:    w = 32'h0932_8580;
			4'd6:    w = 32'h288F_FEDD;
			4'd7:    w = 32'h99EB_F13A;
			4'd8:    w = 32'h5A47_1F95;
			4'd9:    w = 32'h1EA3_F4F1;
			4'd10:   w = 32'hF4FF_524E;
			4'd11:   w = 32'hD358_E8A9;
			4'd12:   w = 32'hC5B7_1015;
			4'd13:   w = 32'hA913_046F;
			4'd14:   w = 32'h2D6F_D2BD;
			default: w = 32'h68C8_BE19;
		endcase
		return w;
	endfunction

endpackage

[sv/kws_key_reg.sv]
// ----------------------------------------------------------------------------
// kws_key_reg
// Key register with the rotate amount derived once per key write.
// ----------------------------------------------------------------------------
module kws_key_reg
	import kws_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [WORD_W-1:0] wr_data,
	output kws_cfg_t          cfg
);

	logic [3:0]  nib_x;
	kws_cfg_t    cfg_q;

	always_comb begin
		nib_x = SHIFT_SEED;
		for (int n = 0; n < 8; n++) begin
			nib_x = nib_x ^ wr_data[4*n +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key <= '0;
			cfg_q.rot <= SHIFT_BASE ^ {1'b0, SHIFT_SEED};
		end else if (wr_en) begin
			cfg_q.key <= wr_data;
			cfg_q.rot <= SHIFT_BASE + {1'b0, nib_x};
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/kws_datapath.sv]
// ----------------------------------------------------------------------------
// kws_datapath
// Combinational scramble of one word or tail and the next table index.
// ----------------------------------------------------------------------------
module kws_datapath
	import kws_pkg::*;
(
	input  kws_cfg_t           cfg,
	input  logic [INDEX_W-1:0] idx,
	input  logic [WORD_W-1:0]  data,
	input  logic [COUNT_W-1:0] count,
	input  logic               last,
	output logic [WORD_W-1:0]  result,
	output logic [INDEX_W-1:0] idx_next
);

	logic [2*WORD_W-1:0] dbl;
	logic [WORD_W-1:0]   rot_word;
	logic [WORD_W-1:0]   pad0, pad1, pad2;
	logic [7:0]          b0, b1, b2;
	logic [INDEX_W-1:0]  adv;

	always_comb begin
		dbl      = {data, data} << cfg.rot;
		rot_word = dbl[2*WORD_W-1:WORD_W];
		pad0     = pad_rom(idx) + cfg.key;
		pad1     = pad_rom(idx + INDEX_W'(1)) + cfg.key;
		pad2     = pad_rom(idx + INDEX_W'(2)) + cfg.key;
		b0       = (data[7:0]   - BYTE_SUB) ^ pad0[7:0];
		b1       = (data[15:8]  - BYTE_SUB) ^ pad1[11:4];
		b2       = (data[23:16] - BYTE_SUB) ^ pad2[15:8];

		if (count[2]) begin
			result = (rot_word + WORD_ADD) ^ pad0;
			adv    = INDEX_W'(1);
		end else begin
			result = '0;
			adv    = INDEX_W'(count[1:0]);
			case (count[1:0])
				2'd1:    result[7:0]  = b0;
				2'd2:    result[15:0] = {b1, b0};
				2'd3:    result[23:0] = {b2, b1, b0};
				default: result       = '0;
			endcase
		end

		idx_next = last ? '0 : idx + adv;
	end

endmodule

[sv/keyed_word_scrambler_core.sv]
// Pipeline: input register, then result register; out_valid rises once an accepted
// word has passed through both registers.
// Throughput: one word per cycle; the input side stalls only when both stages are full
// and out_ready is low.
// Reset: arst_n clears stage valids, table index and key (rotate amount 13).
// Key writes are taken in any cycle and must happen while the pipeline is empty.
// ----------------------------------------------------------------------------
// keyed_word_scrambler_core
// Keyed rotate/add/xor word scrambler with byte-wise tail handling.
// ----------------------------------------------------------------------------
module keyed_word_scrambler_core
	import kws_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WORD_W-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WORD_W-1:0]  data_in,
	input  logic [COUNT_W-1:0] byte_count,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WORD_W-1:0]  data_out,
	output logic [COUNT_W-1:0] byte_count_out,
	output logic               last_out
);

	kws_cfg_t           cfg;
	logic               valid_s1, valid_s2;
	logic [WORD_W-1:0]  data_s1, data_s2;
	logic [COUNT_W-1:0] count_s1, count_s2;
	logic               last_s1, last_s2;
	logic [INDEX_W-1:0] idx_q, idx_next;
	logic [WORD_W-1:0]  result;
	logic               adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	kws_key_reg u_key (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	kws_datapath u_dp (
		.cfg      (cfg),
		.idx      (idx_q),
		.data     (data_s1),
		.count    (count_s1),
		.last     (last_s1),
		.result   (result),
		.idx_next (idx_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				idx_q    <= idx_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_in;
			count_s1 <= byte_count;
			last_s1  <= last_in;
		end
		if (adv_s1) begin
			data_s2  <= result;
			count_s2 <= count_s1;
			last_s2  <= last_s1;
		end
	end

	assign out_valid      = valid_s2;
	assign data_out       = data_s2;
	assign byte_count_out = count_s2;
	assign last_out       = last_s2;

endmodule

[sv/kws_checker.sv]
// ----------------------------------------------------------------------------
// kws_checker
// Port-level checks for keyed_word_scrambler_core, bound to the top level.
// ----------------------------------------------------------------------------
module kws_checker
	import kws_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [WORD_W-1:0]  data_out,
	input logic [COUNT_W-1:0] byte_count_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_out))
		else $error("data_out changed while stalled");

	a_word_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted word did not reach the output");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_count_out[2] |->
			(data_out[31:24] == 8'h00) &&
			(byte_count_out[1:0] == 2'd3 || data_out[23:16] == 8'h00) &&
			(byte_count_out[1] || data_out[15:8] == 8'h00) &&
			(byte_count_out[1:0] != 2'd0 || data_out[7:0] == 8'h00))
		else $error("unused output bytes not zero");

endmodule

bind keyed_word_scrambler_core kws_checker u_kws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.data_out       (data_out),
	.byte_count_out (byte_count_out)
);

[tb/keyed_word_scrambler_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_word_scrambler_core_tb
// Self-checking bench for the keyed word scrambler. A small scoreboard keeps
// its own key and pad index and predicts every scrambled word: full words
// through the key-dependent rotate, add and pad xor, and short tails byte by
// byte. Directed words cover the count and data corners, then random buffers
// run under several keys, with random sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module keyed_word_scrambler_core_tb;
	import kws_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int DRAIN_CYCLES = 6;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 1900;
	localparam int NUM_PHASES   = 8;

	typedef struct packed {
		logic [WORD_W-1:0]  data;
		logic [COUNT_W-1:0] count;
		logic               last;
	} word_t;

	class scramble_scoreboard;
		logic [WORD_W-1:0]  key;
		logic [INDEX_W-1:0] pad_idx;
		logic [WORD_W-1:0]  pad_tbl [16];
		word_t              expected_q [$];
		int                 errors;
		int                 checked;

		function new();
			pad_tbl = '{
				32'h3A68_CDBF, 32'hD3C3_A711, 32'h8414_876E, 32'h657B_EFDB,
				32'hCDD7_C125, 32'h0932_8580, 32'h288F_FEDD, 32'h99EB_F13A,
				32'h5A47_1F95, 32'h1EA3_F4F1, 32'hF4FF_524E, 32'hD358_E8A9,
				32'hC5B7_1015, 32'hA913_046F, 32'h2D6F_D2BD, 32'h68C8_BE19
			};
			key     = '0;
			pad_idx = '0;
			errors  = 0;
			checked = 0;
		endfunction

		function void set_key(input logic [WORD_W-1:0] k);
			key = k;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [WORD_W-1:0] next_pad();
			logic [WORD_W-1:0] p;
			p       = pad_tbl[pad_idx] + key;
			pad_idx = pad_idx + 1'b1;
			return p;
		endfunction

		function void note_input(input word_t w);
			word_t             res;
			logic [3:0]        nib;
			logic [ROT_W-1:0]  rot;
			logic [WORD_W-1:0] rotated;
			logic [WORD_W-1:0] pad;
			logic [7:0]        b;
			res       = '0;
			res.count = w.count;
			res.last  = w.last;
			if (w.count >= 3'd4) begin
				nib = SHIFT_SEED;
				for (int n = 0; n < 8; n++)
					nib ^= key[4*n +: 4];
				rot      = SHIFT_BASE + ROT_W'(nib);
				rotated  = (w.data << rot) | (w.data >> (32 - int'(rot)));
				res.data = (rotated + WORD_ADD) ^ next_pad();
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (i < int'(w.count)) begin
						pad = next_pad() >> (4 * i);
						b   = w.data[8*i +: 8] - BYTE_SUB;
						res.data[8*i +: 8] = b ^ pad[7:0];
					end
				end
			end
			if (w.last)
				pad_idx = '0;
			expected_q = {expected_q, res};
		endfunction

		function void check_result(input word_t got);
			word_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got data=%h count=%0d last=%0d",
					$time, got.data, got.count, got.last);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.data !== want.data) begin
				errors++;
				$display("%0t: data_out expected %h got %h", $time, want.data, got.data);
			end
			if (got.count !== want.count) begin
				errors++;
				$display("%0t: byte_count_out expected %0d got %0d",
					$time, want.count, got.count);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last_out expected %0d got %0d", $time, want.last, got.last);
			end
		endfunction
	endclass

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic [WORD_W-1:0]  cfg_data   = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [WORD_W-1:0]  data_in    = '0;
	logic [COUNT_W-1:0] byte_count = 3'd4;
	logic               last_in    = 1'b0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [WORD_W-1:0]  data_out;
	logic [COUNT_W-1:0] byte_count_out;
	logic               last_out;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int stall_cycles   = 0;
	int words_sent     = 0;
	int buffers_sent   = 0;
	int key_writes     = 0;

	scramble_scoreboard sb = new();

	keyed_word_scrambler_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_in        (data_in),
		.byte_count     (byte_count),
		.last_in        (last_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_out       (data_out),
		.byte_count_out (byte_count_out),
		.last_out       (last_out)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{data: data_out, count: byte_count_out, last: last_out});
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("keyed_word_scrambler_core: mismatch");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] d, input logic [COUNT_W-1:0] c,
			input logic l);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		data_in    <= d;
		byte_count <= c;
		last_in    <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_input('{data: d, count: c, last: l});
		words_sent++;
		if (l)
			buffers_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(input logic [WORD_W-1:0] k);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		do @(posedge clk); while (!cfg_ready);
		sb.set_key(k);
		key_writes++;
		cfg_valid <= 1'b0;
	endtask

	// mostly short buffers, some long enough to wrap the pad index;
	// a few odd counts and short non-final words as noise
	task automatic send_random_buffer();
		int                 len;
		int                 kind;
		logic [WORD_W-1:0]  d;
		logic [COUNT_W-1:0] c;
		len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
		for (int n = 0; n < len; n++) begin
			kind = $urandom_range(99);
			d    = ($urandom_range(15) == 0) ? {WORD_W{kind[0]}} : $urandom;
			if (n == len - 1)
				c = (kind < 4) ? COUNT_W'($urandom_range(7, 0)) : COUNT_W'($urandom_range(4, 1));
			else if (kind < 2)
				c = 3'd0;
			else if (kind < 4)
				c = COUNT_W'($urandom_range(7, 5));
			else if (kind < 7)
				c = COUNT_W'($urandom_range(3, 1));
			else
				c = 3'd4;
			send_word(d, c, n == len - 1);
		end
	endtask

	initial begin
		logic [WORD_W-1:0] phase_key;
		int                target;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key, index walks past 16 and wraps
		send_word(32'h0000_0000, 3'd4, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
		send_word(32'h8000_0001, 3'd4, 1'b0);
		send_word(32'h1234_5678, 3'd4, 1'b0);
		send_word(32'hA5A5_5A5A, 3'd5, 1'b0);
		send_word(32'h0F0F_F0F0, 3'd6, 1'b0);
		send_word(32'hDEAD_BEEF, 3'd7, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
		send_word(32'hFFFF_3637, 3'd2, 1'b0);
		send_word(32'h8000_0036, 3'd3, 1'b0);
		send_word(32'hFFFF_FF00, 3'd1, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
		send_word(32'h0000_0000, 3'd4, 1'b0);
		send_word(32'h7FFF_FFFE, 3'd4, 1'b0);
		send_word(32'hFF37_0000, 3'd3, 1'b1);
		send_word(32'h0000_00FF, 3'd1, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
		send_word(32'hC3C3_C3C3, 3'd4, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
		send_word(32'h0000_0000, 3'd7, 1'b1);
		wait_drained();

		// rotate 23, 13, 8, then random keys; idling mode cycles per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       phase_key = 32'h0000_000A;
				1:       phase_key = 32'hFFFF_FFFF;
				2:       phase_key = 32'h0000_0005;
				default: phase_key = $urandom;
			endcase
			write_key(phase_key);
			case (ph % 4)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			target = words_sent + RANDOM_WORDS / NUM_PHASES;
			while (words_sent < target - RANDOM_WORDS / (2 * NUM_PHASES))
				send_random_buffer();
			wait_drained();
			while (words_sent < target)
				send_random_buffer();
			wait_drained();
		end

		$display("%0d words in %0d buffers checked under %0d keys (rotate 8 to 23),",
			sb.checked, buffers_sent, key_writes + 1);
		$display("all byte counts 0 to 7, with sender gaps and output back-pressure");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("keyed_word_scrambler_core: match");
		end else begin
			$display("keyed_word_scrambler_core: mismatch");
		end
		$finish;
	end

endmodule
